[design/lpm_pkg.sv]
`timescale 1ns / 1ps

package lpm_pkg;

  localparam int CODE_W = 21;
  localparam int IN_DATA_W = 24;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 8;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_LIT = 2'd0;
  localparam kind_t KIND_ONE = 2'd1;
  localparam kind_t KIND_RUN = 2'd2;

  localparam code_t CP_BACKSLASH = 21'h00005C;
  localparam code_t CP_UNDERSCORE = 21'h00005F;
  localparam code_t CP_PERCENT = 21'h000025;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic pattern;
    logic finish;
    logic init;
    logic step;
    logic result;
  } lpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic loading;
    logic text_starting;
    logic item_last;
    logic item_empty;
  } lpm_stat_t;

endpackage

[design/lpm_ctrl.sv]
`timescale 1ns / 1ps

module lpm_ctrl
  import lpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      in_text,
  input  logic      in_last,
  input  logic      in_empty,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  lpm_stat_t stat,
  output lpm_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PATTERN = 3'd1;
  localparam logic [2:0] ST_FINISH  = 3'd2;
  localparam logic [2:0] ST_INIT    = 3'd3;
  localparam logic [2:0] ST_STEP    = 3'd4;
  localparam logic [2:0] ST_RESULT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       result_write;
  logic       m_tvalid_next;

  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  // output register is free when empty or drained this cycle
  assign result_write = (state == ST_RESULT) && (!m_tvalid || m_tready);

  always_comb begin
    cmd = '0;
    cmd.capture = accept;
    cmd.pattern = (state == ST_PATTERN);
    cmd.finish = (state == ST_FINISH);
    cmd.init = (state == ST_INIT);
    cmd.step = (state == ST_STEP);
    cmd.result = result_write;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!in_text) begin
            state_next = ST_PATTERN;
          end else if (stat.loading) begin
            state_next = ST_FINISH;
          end else if (stat.text_starting) begin
            state_next = ST_INIT;
          end else if (!in_empty) begin
            state_next = ST_STEP;
          end else if (in_last) begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_PATTERN: state_next = ST_IDLE;
      ST_FINISH: state_next = ST_INIT;
      ST_INIT: begin
        if (!stat.item_empty) begin
          state_next = ST_STEP;
        end else if (stat.item_last) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_STEP: state_next = stat.item_last ? ST_RESULT : ST_IDLE;
      ST_RESULT: begin
        if (result_write) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (m_tvalid && m_tready) begin
      m_tvalid_next = 1'b0;
    end
    if (result_write) begin
      m_tvalid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

[design/lpm_datapath.sv]
`timescale 1ns / 1ps

module lpm_datapath
  import lpm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lpm_cmd_t              cmd,
  output lpm_stat_t             stat,
  input  code_t                 in_code,
  input  logic                  in_last,
  input  logic                  in_empty,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int N1 = PATTERN_MAX + 1;
  localparam int CW = $clog2(N1);
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // element store, each entry read by its own cell
  kind_t elem_kind [PATTERN_MAX];
  code_t elem_code [PATTERN_MAX];

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          esc;
  logic          esc_next;
  logic          ovf;
  logic          ovf_next;
  logic          loading;
  logic          loading_next;
  logic          text_starting;
  logic          text_starting_next;
  logic [N1-1:0] active;
  logic [N1-1:0] active_next;

  code_t         itm_code;
  logic          itm_last;
  logic          itm_empty;

  logic [CW-1:0] base_count;
  logic          base_esc;
  logic          base_ovf;
  logic          esc_mid;
  logic          push_en;
  kind_t         push_kind;
  code_t         push_code;
  logic          write_en;

  logic [N1-1:0] run_mask;
  logic [N1-1:0] stay_bits;
  logic [N1-1:0] move_bits;
  logic [N1-1:0] stepped;

  assign stat.loading = loading;
  assign stat.text_starting = text_starting;
  assign stat.item_last = itm_last;
  assign stat.item_empty = itm_empty;

  // every position reachable through a chain of percent elements; the chain
  // is a carry ripple with generate = active & run and propagate = run
  function automatic logic [N1-1:0] close_runs(input logic [N1-1:0] s,
                                                input logic [N1-1:0] p);
    logic [N1-1:0] g;
    logic [N1-1:0] carries;
    g = s & p;
    carries = (g + p) ^ g ^ p;
    return s | carries;
  endfunction

  assign run_mask[N1-1] = 1'b0;
  assign stay_bits[N1-1] = 1'b0;
  assign move_bits[0] = 1'b0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic live;
    assign live = active[i] && (count > CW'(i));
    assign run_mask[i] = (count > CW'(i)) && (elem_kind[i] == KIND_RUN);
    assign stay_bits[i] = live && (elem_kind[i] == KIND_RUN);
    assign move_bits[i+1] = live && ((elem_kind[i] == KIND_ONE) ||
                            ((elem_kind[i] == KIND_LIT) && (elem_code[i] == itm_code)));
  end

  assign stepped = stay_bits | move_bits;

  always_comb begin
    base_count = loading ? count : '0;
    base_esc = loading && esc;
    base_ovf = loading && ovf;
    esc_mid = base_esc;
    push_en = 1'b0;
    push_kind = KIND_LIT;
    push_code = itm_code;
    if (cmd.pattern) begin
      if (!itm_empty) begin
        if ((itm_code == CP_BACKSLASH) && !base_esc) begin
          esc_mid = 1'b1;
        end else begin
          push_en = 1'b1;
          esc_mid = 1'b0;
          if (!base_esc && (itm_code == CP_UNDERSCORE)) begin
            push_kind = KIND_ONE;
          end else if (!base_esc && (itm_code == CP_PERCENT)) begin
            push_kind = KIND_RUN;
          end
        end
      end
      // trailing lone backslash stands for itself
      if (itm_last && esc_mid) begin
        push_en = 1'b1;
        push_kind = KIND_LIT;
        push_code = CP_BACKSLASH;
        esc_mid = 1'b0;
      end
    end else if (cmd.finish) begin
      if (base_esc) begin
        push_en = 1'b1;
        push_kind = KIND_LIT;
        push_code = CP_BACKSLASH;
      end
      esc_mid = 1'b0;
    end
  end

  always_comb begin
    count_next = count;
    esc_next = esc;
    ovf_next = ovf;
    loading_next = loading;
    text_starting_next = text_starting;
    write_en = 1'b0;
    active_next = active;
    if (cmd.pattern || cmd.finish) begin
      count_next = base_count;
      esc_next = esc_mid;
      ovf_next = base_ovf;
      text_starting_next = 1'b1;
      loading_next = cmd.pattern && !itm_last;
      if (push_en) begin
        if (base_count >= CW'(PATTERN_MAX)) begin
          ovf_next = 1'b1;
        end else begin
          write_en = 1'b1;
          count_next = base_count + CW'(1);
        end
      end
    end
    if (cmd.init) begin
      text_starting_next = 1'b0;
      active_next = close_runs(N1'(1), run_mask);
    end
    if (cmd.step) begin
      active_next = close_runs(stepped, run_mask);
    end
    if (cmd.result) begin
      text_starting_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      esc <= 1'b0;
      ovf <= 1'b0;
      loading <= 1'b0;
      text_starting <= 1'b1;
      active <= '0;
    end else begin
      count <= count_next;
      esc <= esc_next;
      ovf <= ovf_next;
      loading <= loading_next;
      text_starting <= text_starting_next;
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      elem_kind[base_count[IW-1:0]] <= push_kind;
      elem_code[base_count[IW-1:0]] <= push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      itm_code <= in_code;
      itm_last <= in_last;
      itm_empty <= in_empty;
    end
    if (cmd.result) begin
      out_data <= {(OUT_DATA_W-2)'(0), ovf, !ovf && active[count]};
    end
  end

endmodule

[design/like_pattern_matcher.sv]
`timescale 1ns / 1ps

// channel  dir  tdata                              tuser                    tlast
// s_       in   [20:0] char_code, [23:21] zero     [0] req_type,            last
//                                                  [1] empty_string
// m_       out  [0] matched, [1] pattern_too_long  -                        -
//                [7:2] zero
//
// a pattern item: the transfer, then appending to the element store
// a text item runs through, as needed: closing a loading pattern, seeding the start positions,
// one parallel update of all positions and, on the last item, writing the result
// the update is one compare per element plus one PATTERN_MAX+1 bit add for percent chains
// reset is synchronous; no clearing pass, the element store is read only below the count
// while a result waits in the output register new items are still taken; a last text item
// holds the input side only until that register is free

module like_pattern_matcher
  import lpm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // char_code, zero fill
  input  logic [IN_USER_W-1:0]  s_tuser,  // req_type, empty_string
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // matched, pattern_too_long, zero fill
);

  lpm_cmd_t  cmd;
  lpm_stat_t stat;

  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_text  (s_tuser[0]),
    .in_last  (s_tlast),
    .in_empty (s_tuser[1]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpm_datapath #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_code  (s_tdata[CODE_W-1:0]),
    .in_last  (s_tlast),
    .in_empty (s_tuser[1]),
    .out_data (m_tdata)
  );

endmodule

[design/lpm_checker.sv]
`timescale 1ns / 1ps

module lpm_checker
  import lpm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_USER_W-1:0]  s_tuser,
  input logic                  s_tlast,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an overflowed pattern never reports a match
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("match reported for an overflowed pattern");

  // only a last text item can raise a result
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (!s_tuser[0] || !s_tlast) |=> !$rose(m_tvalid))
    else $error("result raised by a pattern or inner text transfer");

  // nothing is offered straight out of reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind like_pattern_matcher lpm_checker u_lpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[dv/tb_like_pattern_matcher.sv]
`timescale 1ns / 1ps

module tb_like_pattern_matcher
  import lpm_pkg::*;
();

  localparam int PAT_MAX = 32;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_FROM = 850;
  localparam bit REQ_PATTERN = 1'b0;
  localparam bit REQ_TEXT = 1'b1;
  localparam code_t CP_NEWLINE = 21'h00000A;
  localparam code_t CP_TOP = 21'h1FFFFF;

  typedef struct packed {
    logic matched;
    logic too_long;
  } verdict_t;

  // mirrors the matcher state and queues the verdict each last text item should give
  class like_match_scoreboard;
    kind_t elem_kind[PAT_MAX];
    code_t elem_code[PAT_MAX];
    int elem_cnt;
    bit esc_pending;
    bit overflow;
    bit loading;
    bit text_fresh;
    bit [PAT_MAX:0] live;
    verdict_t due_verdicts[$];
    int errors;
    int n_checked;
    int n_true;
    int n_overflow;

    function new();
      elem_cnt = 0;
      esc_pending = 0;
      overflow = 0;
      loading = 0;
      text_fresh = 1;
      live = '0;
      errors = 0;
      n_checked = 0;
      n_true = 0;
      n_overflow = 0;
    endfunction

    function int pending();
      return due_verdicts.size();
    endfunction

    function void append_elem(kind_t k, code_t c);
      if (elem_cnt >= PAT_MAX) begin
        overflow = 1;
        return;
      end
      elem_kind[elem_cnt] = k;
      elem_code[elem_cnt] = c;
      elem_cnt++;
    endfunction

    function void compile_char(code_t c);
      if (c == CP_BACKSLASH && !esc_pending) begin
        esc_pending = 1;
        return;
      end
      if (!esc_pending && c == CP_UNDERSCORE) append_elem(KIND_ONE, '0);
      else if (!esc_pending && c == CP_PERCENT) append_elem(KIND_RUN, '0);
      else append_elem(KIND_LIT, c);
      esc_pending = 0;
    endfunction

    function void close_pattern();
      // a dangling escape stands for a literal backslash
      if (esc_pending) append_elem(KIND_LIT, CP_BACKSLASH);
      esc_pending = 0;
      loading = 0;
      text_fresh = 1;
    endfunction

    // a live percent also lets the position after it go live, cascading
    function void skip_runs();
      for (int i = 0; i < elem_cnt; i++)
        if (live[i] && elem_kind[i] == KIND_RUN) live[i+1] = 1'b1;
    endfunction

    function void advance(code_t c);
      bit [PAT_MAX:0] nxt;
      nxt = '0;
      for (int i = 0; i < elem_cnt; i++) begin
        if (live[i]) begin
          if (elem_kind[i] == KIND_RUN) nxt[i] = 1'b1;
          else if (elem_kind[i] == KIND_ONE) nxt[i+1] = 1'b1;
          else if (elem_code[i] == c) nxt[i+1] = 1'b1;
        end
      end
      live = nxt;
      skip_runs();
    endfunction

    function void note_item(bit is_text, code_t c, bit is_last, bit no_char);
      verdict_t v;
      if (!is_text) begin
        if (!loading) begin
          elem_cnt = 0;
          esc_pending = 0;
          overflow = 0;
          loading = 1;
          text_fresh = 1;
        end
        if (!no_char) compile_char(c);
        if (is_last) close_pattern();
        return;
      end
      if (loading) close_pattern();
      if (text_fresh) begin
        live = '0;
        live[0] = 1'b1;
        skip_runs();
        text_fresh = 0;
      end
      if (!no_char) advance(c);
      if (is_last) begin
        v.matched = !overflow && live[elem_cnt];
        v.too_long = overflow;
        due_verdicts.insert(due_verdicts.size(), v);
        text_fresh = 1;
      end
    endfunction

    function void check_verdict(logic matched, logic too_long);
      verdict_t exp_v;
      if (due_verdicts.size() == 0) begin
        $error("result transfer with nothing expected: matched=%0b pattern_too_long=%0b",
               matched, too_long);
        errors++;
        return;
      end
      exp_v = due_verdicts.pop_front();
      n_checked++;
      if (exp_v.matched) n_true++;
      if (exp_v.too_long) n_overflow++;
      if (matched !== exp_v.matched) begin
        $error("matched: expected %0b, got %0b", exp_v.matched, matched);
        errors++;
      end
      if (too_long !== exp_v.too_long) begin
        $error("pattern_too_long: expected %0b, got %0b", exp_v.too_long, too_long);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // char_code, zero fill
  logic [IN_USER_W-1:0] s_tuser = '0;   // req_type, empty_string
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // matched, pattern_too_long, zero fill

  like_match_scoreboard sb = new();
  int accepted_items = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  int long_holds_wanted = 0;
  int long_holds_done = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  like_pattern_matcher #(.PATTERN_MAX(PAT_MAX)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // transfer monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_item(s_tuser[0], s_tdata[CODE_W-1:0], s_tlast, s_tuser[1]);
        accepted_items++;
      end
      if (m_tvalid && m_tready) sb.check_verdict(m_tdata[0], m_tdata[1]);
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (long_holds_done != long_holds_wanted) begin
      long_holds_done++;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input bit is_text, input code_t c, input bit is_last,
                           input bit no_char);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-CODE_W){1'b0}}, c};
    s_tuser <= {no_char, is_text};
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_string(input bit is_text, input string s);
    if (s.len() == 0) begin
      send_item(is_text, '0, 1'b1, 1'b1);
      return;
    end
    for (int i = 0; i < s.len(); i++)
      send_item(is_text, code_t'(s[i]), i == s.len() - 1, 1'b0);
  endtask

  // close = 0 leaves the string open so the next text item has to close the pattern
  task automatic send_codes(input bit is_text, input code_t q[$], input bit close);
    int n;
    n = q.size();
    if (n == 0) begin
      if (close) send_item(is_text, '0, 1'b1, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(is_text, '0, 1'b0, 1'b1);
      if (close && i == n - 1 && $urandom_range(0, 7) == 0) begin
        send_item(is_text, q[i], 1'b0, 1'b0);
        send_item(is_text, '0, 1'b1, 1'b1);
      end else begin
        send_item(is_text, q[i], close && i == n - 1, 1'b0);
      end
    end
  endtask

  function automatic code_t rand_code();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return code_t'("a") + code_t'($urandom_range(0, 2));
    if (r == 14) return CP_NEWLINE;
    if (r == 15) return CP_BACKSLASH;
    if (r == 16) return CP_UNDERSCORE;
    if (r == 17) return CP_PERCENT;
    return code_t'($urandom_range(0, CP_TOP));
  endfunction

  // one pattern followed by a few texts, most of them built to fit the pattern
  task automatic send_like_case();
    kind_t tk_kind[$];
    code_t tk_code[$];
    code_t pat[$];
    code_t txt[$];
    int n_tok;
    int k;
    bit open_end;
    n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
    for (int i = 0; i < n_tok; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        tk_kind.insert(tk_kind.size(), KIND_LIT);
        tk_code.insert(tk_code.size(), rand_code());
      end else if (k < 8) begin
        tk_kind.insert(tk_kind.size(), KIND_ONE);
        tk_code.insert(tk_code.size(), code_t'(0));
      end else begin
        tk_kind.insert(tk_kind.size(), KIND_RUN);
        tk_code.insert(tk_code.size(), code_t'(0));
      end
    end
    foreach (tk_kind[i]) begin
      if (tk_kind[i] == KIND_ONE) begin
        pat.insert(pat.size(), CP_UNDERSCORE);
      end else if (tk_kind[i] == KIND_RUN) begin
        pat.insert(pat.size(), CP_PERCENT);
      end else begin
        if (tk_code[i] == CP_BACKSLASH || tk_code[i] == CP_UNDERSCORE ||
            tk_code[i] == CP_PERCENT || $urandom_range(0, 7) == 0)
          pat.insert(pat.size(), CP_BACKSLASH);
        pat.insert(pat.size(), tk_code[i]);
      end
    end
    // lone trailing backslash reads as a literal one
    if ($urandom_range(0, 7) == 0) begin
      pat.insert(pat.size(), CP_BACKSLASH);
      tk_kind.insert(tk_kind.size(), KIND_LIT);
      tk_code.insert(tk_code.size(), CP_BACKSLASH);
    end
    open_end = (pat.size() > 0) && ($urandom_range(0, 9) == 0);
    send_codes(REQ_PATTERN, pat, !open_end);
    repeat ($urandom_range(1, 4)) begin
      txt.delete();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(0, 6)) txt.insert(txt.size(), rand_code());
      end else begin
        foreach (tk_kind[i]) begin
          if (tk_kind[i] == KIND_LIT) txt.insert(txt.size(), tk_code[i]);
          else if (tk_kind[i] == KIND_ONE) txt.insert(txt.size(), rand_code());
          else repeat ($urandom_range(0, 3)) txt.insert(txt.size(), rand_code());
        end
        if ($urandom_range(0, 3) == 0) begin
          if (txt.size() > 0 && $urandom_range(0, 1))
            txt[$urandom_range(0, txt.size() - 1)] = rand_code();
          else txt.insert(txt.size(), rand_code());
        end
      end
      send_codes(REQ_TEXT, txt, 1'b1);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_item(1'($urandom_range(0, 1)), code_t'($urandom_range(0, CP_TOP)),
                $urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0);
  endtask

  initial begin
    bit did_hold;
    bit did_drain;
    did_hold = 0;
    did_drain = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // nothing loaded yet acts as the empty pattern
    send_string(REQ_TEXT, "a");
    send_string(REQ_TEXT, "");
    // explicit empty pattern
    send_string(REQ_PATTERN, "");
    send_string(REQ_TEXT, "");
    send_string(REQ_TEXT, "x");
    // underscore takes a newline too
    send_string(REQ_PATTERN, "a_%");
    send_string(REQ_TEXT, "a\nqq");
    // escaped percent plus a dangling backslash
    send_string(REQ_PATTERN, "\\%\\");
    send_string(REQ_TEXT, "%\\");
    // text arriving while the pattern is still open
    send_item(REQ_PATTERN, code_t'("b"), 1'b0, 1'b0);
    send_item(REQ_TEXT, code_t'("b"), 1'b1, 1'b0);
    // code point extremes, with empty items inside the strings
    send_item(REQ_PATTERN, '0, 1'b0, 1'b1);
    send_item(REQ_PATTERN, CP_TOP, 1'b0, 1'b0);
    send_item(REQ_PATTERN, '0, 1'b1, 1'b0);
    send_item(REQ_TEXT, '0, 1'b0, 1'b1);
    send_item(REQ_TEXT, CP_TOP, 1'b0, 1'b0);
    send_item(REQ_TEXT, '0, 1'b0, 1'b0);
    send_item(REQ_TEXT, '0, 1'b1, 1'b1);

    while (accepted_items < RANDOM_ITEMS) begin
      if (!did_hold && accepted_items >= 300) begin
        did_hold = 1;
        long_holds_wanted++;
        // short texts keep coming while results back up
        repeat (24) send_item(REQ_TEXT, rand_code(), 1'b1, 1'b0);
      end
      if (!did_drain && accepted_items >= 600) begin
        did_drain = 1;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (accepted_items >= QUIET_FROM) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_like_case();
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("results: expected %0d more, got none", sb.pending());
      sb.errors++;
    end

    $display("%0d input transfers, %0d verdicts checked: %0d matches, %0d overflowed patterns",
             accepted_items, sb.n_checked, sb.n_true, sb.n_overflow);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/lpm_pkg.sv
design/lpm_ctrl.sv
design/lpm_datapath.sv
design/like_pattern_matcher.sv
design/lpm_checker.sv
dv/tb_like_pattern_matcher.sv
